/* rtl/shwt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence high-water table package
// Operation and status codes and the sequencer state type shared by the
// table core.
// ----------------------------------------------------------------------------
package shwt_pkg;

	localparam int SEQ_W = 32;
	localparam int GW_ID_W = 64;

	typedef enum logic [1:0] {
		MODE_LOOKUP  = 2'd0,
		MODE_COMMIT  = 2'd1,
		MODE_RESTORE = 2'd2,
		MODE_IGNORE  = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_PERSIST   = 2'd3;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_SCAN   = 2'd1,
		FSM_DRAIN  = 2'd2,
		FSM_DECIDE = 2'd3
	} fsm_t;

endpackage

/* rtl/sequence_high_water_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence high-water table core
// Per-gateway anti-replay sequence marks with lookup, commit and restore; the fourth mode only answers OK.
// ----------------------------------------------------------------------------
// Each request word is one operation. The core walks the identifier memory
// one entry per cycle through a single comparator, noting the matching entry
// and the lowest free entry, then decides and, where the mode calls for it,
// writes back. req_stall stays high from the walk until that decision is
// made, so a new request is taken only once the last one is decided. The
// response sits in an output register, so a new request is taken while an
// earlier response still waits on rsp_stall; its decision then waits until
// that response has gone.
module sequence_high_water_table_core #(
	parameter int ENTRIES = 8,
	parameter int ID_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   mode,
	input  logic [shwt_pkg::GW_ID_W-1:0] gateway_id,
	input  logic [shwt_pkg::SEQ_W-1:0]   new_seq,
	input  logic                         persist_ok,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [1:0]                   status,
	output logic [shwt_pkg::SEQ_W-1:0]   seq_out,
	output logic                         store_updated
);

	import shwt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ID_W = 8 * ID_BYTES;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	fsm_t state_q, state_d;

	mode_t             mode_q;
	logic [ID_W-1:0]   id_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              persist_q;

	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               issue_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [SEQ_W-1:0]  hit_seq_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [SEQ_W-1:0]  seq_out_q;
	logic              updated_q;

	logic              accept;
	logic              scan_issue;
	logic              out_free;
	logic              decide_go;
	logic              do_write;
	logic [IDX_W-1:0]  ram_addr;
	logic [ID_W-1:0]   rd_id;
	logic [SEQ_W-1:0]  rd_seq;
	logic              id_match;

	logic [1:0]        dec_status;
	logic [SEQ_W-1:0]  dec_seq_out;
	logic              dec_write;
	logic [IDX_W-1:0]  tgt_idx;

	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign id_match = valid_q[idx_s1] && (rd_id == id_q);
	assign do_write = decide_go && dec_write;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (req_valid) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (scan_idx_q == LAST_IDX) begin
					state_d = FSM_DRAIN;
				end
			end
			FSM_DRAIN: begin
				state_d = FSM_DECIDE;
			end
			FSM_DECIDE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall  = (state_q != FSM_IDLE);
		scan_issue = (state_q == FSM_SCAN);
		decide_go  = (state_q == FSM_DECIDE) && out_free;
		ram_addr   = (state_q == FSM_DECIDE) ? tgt_idx : scan_idx_q;
	end

	always_comb begin
		dec_status  = ST_OK;
		dec_seq_out = '0;
		dec_write   = 1'b0;
		tgt_idx     = hit_q ? hit_idx_q : free_idx_q;
		case (mode_q)
			MODE_LOOKUP: begin
				if (hit_q) begin
					dec_seq_out = hit_seq_q;
				end else begin
					dec_status = ST_NOT_FOUND;
				end
			end
			MODE_COMMIT: begin
				if (hit_q && (hit_seq_q >= seq_q)) begin
					dec_status = ST_OK;
				end else if (!hit_q && !free_q) begin
					dec_status = ST_FULL;
				end else if (!persist_q) begin
					dec_status = ST_PERSIST;
				end else begin
					dec_write = 1'b1;
				end
			end
			MODE_RESTORE: begin
				if (hit_q || free_q) begin
					dec_write = 1'b1;
				end else begin
					dec_status = ST_FULL;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	shwt_ram #(
		.WIDTH(ID_W),
		.DEPTH(ENTRIES)
	) u_id_ram (
		.clk  (clk),
		.addr (ram_addr),
		.we   (do_write),
		.wdata(id_q),
		.rdata(rd_id)
	);

	shwt_ram #(
		.WIDTH(SEQ_W),
		.DEPTH(ENTRIES)
	) u_seq_ram (
		.clk  (clk),
		.addr (ram_addr),
		.we   (do_write),
		.wdata(seq_q),
		.rdata(rd_seq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			valid_q     <= '0;
			scan_idx_q  <= '0;
			issue_s1    <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= scan_issue;
			if (accept) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else if (scan_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (issue_s1) begin
				if (id_match) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (do_write) begin
				valid_q[tgt_idx] <= 1'b1;
			end
			if (decide_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (accept) begin
			mode_q    <= mode_t'(mode);
			id_q      <= gateway_id[ID_W-1:0];
			seq_q     <= new_seq;
			persist_q <= persist_ok;
		end
		if (issue_s1) begin
			if (id_match) begin
				hit_idx_q <= idx_s1;
				hit_seq_q <= rd_seq;
			end
			if (!valid_q[idx_s1] && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (decide_go) begin
			status_q  <= dec_status;
			seq_out_q <= dec_seq_out;
			updated_q <= dec_write;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign seq_out       = seq_out_q;
	assign store_updated = updated_q;

`ifndef SYNTHESIS
	a_alloc_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_write && !hit_q |-> free_q)
		else $error("Allocation without a free entry.");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> valid_q[$past(tgt_idx)])
		else $error("Written entry not marked valid.");

	a_updated_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && updated_q |-> status_q == ST_OK && seq_out_q == '0)
		else $error("Update reported with a bad status or a value.");

	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DECIDE && mode_q == MODE_LOOKUP |-> !do_write)
		else $error("Lookup wrote the table.");
`endif

endmodule

/* rtl/shwt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic single-port memory with one write or read per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module shwt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic                                   we,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
